// ----- rtl/rbgi_pkg.sv -----
// Shared types and constants of the rotating beam gain interpolator.
package rbgi_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int MUL_STEPS       = 32;
   localparam int DIV_STEPS       = 52;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [2:0] CSR_SPEED  = 3'd0;
   localparam logic [2:0] CSR_MODE   = 3'd1;
   localparam logic [2:0] CSR_GAIN   = 3'd2;
   localparam logic [2:0] CSR_WINDOW = 3'd3;
   localparam logic [2:0] CSR_COUNT  = 3'd4;

   localparam logic [31:0] RST_GAIN   = 32'd65536;
   localparam logic [15:0] RST_WINDOW = 16'd8192;
   localparam logic [6:0]  RST_COUNT  = 7'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TICK_MUL, ST_TICK_ADD, ST_Q_WIN, ST_Q_PRIME, ST_Q_FETCH, ST_Q_CMP,
      ST_SEG, ST_MUL, ST_DIV, ST_VAL, ST_GSET, ST_GMUL, ST_GFIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic tick_mul;
      logic tick_add;
      logic prime;
      logic step_hit;
      logic step_miss;
      logic seg_setup;
      logic mul_step;
      logic div_setup;
      logic div_step;
      logic val;
      logic gain_setup;
      logic gain_fin;
      logic res_load;
   } dp_cmd_type;

   typedef struct packed {
      logic in_win;
      logic few;
      logic hit_now;
      logic last;
      logic seg_eq;
      logic mul_last;
      logic div_last;
      logic rcv;
      logic out_busy;
   } dp_status_type;

endpackage

// ----- rtl/rotating_beam_gain_interpolator.sv -----
// Top level of the rotating beam gain interpolator.
// A load word writes one pattern table entry and is done in its accept cycle. A tick word
// multiplies speed by elapsed time, then adds the product into the beam angle. A query
// checks the window, primes the first entry, walks the segments (a fetch and a compare
// each) through the single registered read port of the table, then runs a setup step, 32
// multiply steps, 52 divide steps and a value step for a sloped segment (a flat one needs
// only the setup step), in receive mode a gain setup, multiply and finish, then the result
// load; out-of-window queries go straight to the load. A query whose result finds the
// output register still held waits in its done state until the register drains. A
// finished result sits in the output register while the next word is already taken.
module rotating_beam_gain_interpolator #(
   parameter int TABLE_DEPTH = rbgi_pkg::DEF_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_entry_index,
   input  logic signed [15:0] req_entry_angle,
   input  logic signed [15:0] req_entry_value,
   input  logic [15:0]        req_time_delta,
   input  logic [15:0]        req_target_azimuth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_gain,
   output logic               rsp_in_beam,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import rbgi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   rbgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbgi_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_entry_angle    (req_entry_angle),
      .req_entry_value    (req_entry_value),
      .req_time_delta     (req_time_delta),
      .req_target_azimuth (req_target_azimuth),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_gain           (rsp_gain),
      .rsp_in_beam        (rsp_in_beam),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

// ----- rtl/rbgi_ctrl.sv -----
// Sequencer of the rotating beam gain interpolator.
module rbgi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_stall,
   input  rbgi_pkg::dp_status_type sts,
   output rbgi_pkg::dp_cmd_type   cmd
);
   import rbgi_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_TICK:  state_in = ST_TICK_MUL;
                  CMD_QUERY: state_in = ST_Q_WIN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK_MUL: state_in = ST_TICK_ADD;
         ST_TICK_ADD: state_in = ST_IDLE;
         ST_Q_WIN:    state_in = (sts.in_win && !sts.few) ? ST_Q_PRIME : ST_DONE;
         ST_Q_PRIME:  state_in = ST_Q_FETCH;
         ST_Q_FETCH:  state_in = ST_Q_CMP;
         ST_Q_CMP: begin
            if (sts.hit_now)   state_in = ST_SEG;
            else if (sts.last) state_in = ST_DONE;
            else               state_in = ST_Q_FETCH;
         end
         ST_SEG: begin
            if (sts.seg_eq) state_in = sts.rcv ? ST_GSET : ST_DONE;
            else            state_in = ST_MUL;
         end
         ST_MUL:  state_in = sts.mul_last ? ST_DIV : ST_MUL;
         ST_DIV:  state_in = sts.div_last ? ST_VAL : ST_DIV;
         ST_VAL:  state_in = sts.rcv ? ST_GSET : ST_DONE;
         ST_GSET: state_in = ST_GMUL;
         ST_GMUL: state_in = sts.mul_last ? ST_GFIN : ST_GMUL;
         ST_GFIN: state_in = ST_DONE;
         ST_DONE: state_in = sts.out_busy ? ST_DONE : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.tick_mul   = (state_ff == ST_TICK_MUL);
      cmd.tick_add   = (state_ff == ST_TICK_ADD);
      cmd.prime      = (state_ff == ST_Q_PRIME);
      cmd.step_hit   = (state_ff == ST_Q_CMP) && sts.hit_now;
      cmd.step_miss  = (state_ff == ST_Q_CMP) && !sts.hit_now;
      cmd.seg_setup  = (state_ff == ST_SEG);
      cmd.mul_step   = (state_ff == ST_MUL) || (state_ff == ST_GMUL);
      cmd.div_setup  = (state_ff == ST_MUL) && sts.mul_last;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.val        = (state_ff == ST_VAL);
      cmd.gain_setup = (state_ff == ST_GSET);
      cmd.gain_fin   = (state_ff == ST_GFIN);
      cmd.res_load   = (state_ff == ST_DONE) && !sts.out_busy;
   end

endmodule

// ----- rtl/rbgi_dp.sv -----
// Datapath: registers, pattern table, shift-add multiplier and divider.
module rbgi_dp #(
   parameter int TABLE_DEPTH = rbgi_pkg::DEF_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_cmd,
   input  logic [5:0]             req_entry_index,
   input  logic signed [15:0]     req_entry_angle,
   input  logic signed [15:0]     req_entry_value,
   input  logic [15:0]            req_time_delta,
   input  logic [15:0]            req_target_azimuth,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_gain,
   output logic                   rsp_in_beam,
   input  rbgi_pkg::dp_cmd_type   cmd,
   output rbgi_pkg::dp_status_type sts
);
   import rbgi_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
   localparam int IW = ((AW > 6) ? AW : 6) + 1;

   // configuration
   logic [31:0] speed_ff, gain_ff;
   logic        mode_ff;
   logic [15:0] window_ff;
   logic [6:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= '0;
         mode_ff   <= 1'b0;
         gain_ff   <= RST_GAIN;
         window_ff <= RST_WINDOW;
         count_ff  <= RST_COUNT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SPEED:  speed_ff  <= csr_wdata;
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            CSR_GAIN:   gain_ff   <= csr_wdata;
            CSR_WINDOW: window_ff <= csr_wdata[15:0];
            CSR_COUNT:  count_ff  <= csr_wdata[6:0];
            default:    ;
         endcase
      end
   end

   // pattern table
   logic [15:0] ang_mem [TABLE_DEPTH];
   logic [15:0] val_mem [TABLE_DEPTH];
   logic [15:0] rd_ang_ff, rd_val_ff;
   logic [CW-1:0] idx_ff, cnt;
   logic [IW-1:0] widx;
   logic          we;

   assign widx = IW'(req_entry_index);
   assign we   = cmd.capture && (req_cmd == CMD_LOAD) && (widx < IW'(TABLE_DEPTH));
   assign cnt  = (CW'(count_ff) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         ang_mem[widx[AW-1:0]] <= req_entry_angle;
         val_mem[widx[AW-1:0]] <= req_entry_value;
      end
      rd_ang_ff <= ang_mem[idx_ff[AW-1:0]];
      rd_val_ff <= val_mem[idx_ff[AW-1:0]];
   end

   // beam angle and query capture
   logic [31:0]        beam_ff;
   logic [15:0]        delta_ff;
   logic [47:0]        adv_ff;
   logic signed [34:0] d_ff;
   logic signed [15:0] prev_ang_ff, prev_val_ff, cur_ang_ff, cur_val_ff;
   logic               hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff <= '0;
      end else if (cmd.tick_add) begin
         beam_ff <= beam_ff + adv_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         delta_ff <= req_time_delta;
         d_ff     <= 35'($signed({1'b0, req_target_azimuth, 16'h0}))
                     - 35'($signed({1'b0, beam_ff}));
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
      end
      if (cmd.tick_mul) begin
         adv_ff <= speed_ff * delta_ff;
      end
      if (cmd.prime) begin
         prev_ang_ff <= rd_ang_ff;
         prev_val_ff <= rd_val_ff;
         idx_ff      <= CW'(1);
      end
      if (cmd.step_miss) begin
         prev_ang_ff <= rd_ang_ff;
         prev_val_ff <= rd_val_ff;
         idx_ff      <= idx_ff + CW'(1);
      end
      if (cmd.step_hit) begin
         cur_ang_ff <= rd_ang_ff;
         cur_val_ff <= rd_val_ff;
         hit_ff     <= 1'b1;
      end
   end

   // segment terms
   logic signed [34:0] wpos, diff;
   logic [34:0]        diff_mag;
   logic signed [16:0] dy, dx;
   logic [16:0]        dy_mag, dx_mag;

   assign wpos     = $signed(35'({window_ff, 16'h0}));
   assign diff     = d_ff - 35'($signed({prev_ang_ff, 16'h0}));
   assign diff_mag = diff[34] ? 35'(-diff) : 35'(diff);
   assign dy       = 17'(cur_val_ff) - 17'(prev_val_ff);
   assign dx       = 17'(cur_ang_ff) - 17'(prev_ang_ff);
   assign dy_mag   = dy[16] ? 17'(-dy) : 17'(dy);
   assign dx_mag   = dx[16] ? 17'(-dx) : 17'(dx);

   // shared shift-add multiplier, restoring divider, value register
   logic [67:0]        acc_ff, mcand_ff, rsum;
   logic [31:0]        mplier_ff, den_ff, rem_ff;
   logic [51:0]        num_ff;
   logic [5:0]         iter_ff;
   logic               neg_ff, gneg_ff;
   logic signed [53:0] v_ff, qs, rs;
   logic [53:0]        vmag;
   logic [32:0]        r2;

   assign r2   = {rem_ff, num_ff[51]};
   assign qs   = $signed({2'b0, num_ff});
   assign vmag = v_ff[53] ? 54'(-v_ff) : 54'(v_ff);
   assign rsum = acc_ff + 68'd32768;
   assign rs   = $signed({2'b0, rsum[67:16]});

   always_ff @(posedge clock) begin
      if (cmd.seg_setup) begin
         if (cur_ang_ff == prev_ang_ff) begin
            v_ff <= 54'(cur_val_ff) <<< 1;
         end else begin
            mcand_ff  <= 68'({diff_mag, 1'b0});
            mplier_ff <= 32'(dy_mag[15:0]);
            acc_ff    <= '0;
            neg_ff    <= diff[34] ^ dy[16] ^ dx[16];
            den_ff    <= {dx_mag[15:0], 16'h0};
            iter_ff   <= '0;
         end
      end
      if (cmd.gain_setup) begin
         mcand_ff  <= 68'(vmag);
         mplier_ff <= gain_ff;
         acc_ff    <= '0;
         gneg_ff   <= v_ff[53];
         iter_ff   <= '0;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         // restart the step count when the divider takes over
         iter_ff   <= cmd.div_setup ? 6'd0 : iter_ff + 6'd1;
      end
      if (cmd.div_setup) begin
         // add half the divisor for round to nearest, ties away from zero
         num_ff  <= acc_ff[51:0] + 52'(den_ff >> 1);
         rem_ff  <= '0;
      end
      if (cmd.div_step) begin
         if (r2 >= {1'b0, den_ff}) begin
            rem_ff <= 32'(r2 - {1'b0, den_ff});
            num_ff <= {num_ff[50:0], 1'b1};
         end else begin
            rem_ff <= r2[31:0];
            num_ff <= {num_ff[50:0], 1'b0};
         end
         iter_ff <= iter_ff + 6'd1;
      end
      if (cmd.val) begin
         v_ff <= (54'(prev_val_ff) <<< 1) + (neg_ff ? -qs : qs);
      end
      if (cmd.gain_fin) begin
         v_ff <= gneg_ff ? -rs : rs;
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic signed [31:0] gain_out_ff;
   logic               in_beam_ff;
   logic signed [31:0] sat;

   always_comb begin
      if (v_ff > 54'sd2147483647)       sat = 32'sh7FFFFFFF;
      else if (v_ff < -54'sd2147483648) sat = 32'sh80000000;
      else                              sat = v_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         gain_out_ff <= hit_ff ? sat : '0;
         in_beam_ff  <= hit_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gain    = gain_out_ff;
   assign rsp_in_beam = in_beam_ff;

   always_comb begin
      sts          = '0;
      sts.in_win   = (d_ff > -wpos) && (d_ff < wpos);
      sts.few      = (cnt < CW'(2));
      sts.hit_now  = 35'($signed({rd_ang_ff, 16'h0})) >= d_ff;
      sts.last     = (idx_ff + CW'(1)) == cnt;
      sts.seg_eq   = (cur_ang_ff == prev_ang_ff);
      sts.mul_last = (iter_ff == 6'(MUL_STEPS - 1));
      sts.div_last = (iter_ff == 6'(DIV_STEPS - 1));
      sts.rcv      = mode_ff;
      sts.out_busy = rsp_valid_ff && rsp_stall;
   end

endmodule

// ----- rtl/rbgi_checker.sv -----
// Port-level checks of the rotating beam gain interpolator, bound to the top level.
module rbgi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_gain,
   input logic        rsp_in_beam
);
   import rbgi_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gain) && $stable(rsp_in_beam))
      else $error("stalled result changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_beam |-> rsp_gain == 32'd0)
      else $error("miss with nonzero gain");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_QUERY || req_cmd == CMD_TICK) |=> req_stall)
      else $error("query or tick did not occupy the block");

endmodule

bind rotating_beam_gain_interpolator rbgi_checker u_rbgi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_cmd     (req_cmd),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_gain    (rsp_gain),
   .rsp_in_beam (rsp_in_beam)
);
